// ----- src/toy_accumulator_cpu_execute_core_defines.svh -----
// assertion macros shared by the execute core
`ifndef TOY_ACCUMULATOR_CPU_EXECUTE_CORE_DEFINES_SVH
`define TOY_ACCUMULATOR_CPU_EXECUTE_CORE_DEFINES_SVH

// implication checked on every edge outside reset
`define TAC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// implication checked in the next cycle
`define TAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- src/tac_pkg.sv -----
package tac_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int HEAP_DEPTH  = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int HA_W        = $clog2(HEAP_DEPTH);

  localparam logic [7:0] OP_HALT = 8'h00;
  localparam logic [7:0] OP_LDR0 = 8'h01;
  localparam logic [7:0] OP_LDR1 = 8'h02;
  localparam logic [7:0] OP_ADD  = 8'h03;
  localparam logic [7:0] OP_STOR = 8'h04;
  localparam logic [7:0] OP_PRT  = 8'h05;
  localparam logic [7:0] OP_BEEP = 8'h06;
  localparam logic [7:0] OP_MULT = 8'h07;
  localparam logic [7:0] OP_DIV  = 8'h08;
  localparam logic [7:0] OP_SUB  = 8'h09;
  localparam logic [7:0] OP_JEQ  = 8'h0A;
  localparam logic [7:0] OP_JNE  = 8'h0B;
  localparam logic [7:0] OP_JLT  = 8'h0C;
  localparam logic [7:0] OP_JGT  = 8'h0D;
  localparam logic [7:0] OP_CALL = 8'h0E;
  localparam logic [7:0] OP_RET  = 8'h0F;
  localparam logic [7:0] OP_INT  = 8'h10;
  localparam logic [7:0] OP_CMP  = 8'h11;
  localparam logic [7:0] OP_JNZ  = 8'h12;
  localparam logic [7:0] OP_JMP  = 8'h13;
  localparam logic [7:0] OP_JZ   = 8'h14;
  localparam logic [7:0] OP_INC0 = 8'h15;
  localparam logic [7:0] OP_INC1 = 8'h16;
  localparam logic [7:0] OP_DEC0 = 8'h17;
  localparam logic [7:0] OP_DEC1 = 8'h18;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_BADOP = 3'd1;
  localparam logic [2:0] FLT_DIV0  = 3'd2;
  localparam logic [2:0] FLT_OVFL  = 3'd3;
  localparam logic [2:0] FLT_UNFL  = 3'd4;

  // decoded instruction classes
  typedef enum logic [3:0] {
    K_NOP, K_HALT, K_LDR0, K_LDR1, K_ALU, K_STOR, K_PRT, K_BEEP,
    K_DIV, K_JCC, K_CALL, K_RET, K_JMP, K_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] opcode;
    logic [7:0] operand;
  } dec_t;

  typedef struct packed {
    logic [7:0] next_fetch_address;
    logic       halted;
    logic       print_valid;
    logic [7:0] print_address;
    logic [7:0] print_value;
    logic       beep;
    logic [2:0] fault;
  } res_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
  } req_t;

  function automatic kind_t classify(input logic [7:0] op);
    kind_t k;
    k = K_BAD;
    case (op)
      OP_HALT: k = K_HALT;
      OP_LDR0: k = K_LDR0;
      OP_LDR1: k = K_LDR1;
      OP_ADD, OP_MULT, OP_SUB, OP_INC0, OP_INC1, OP_DEC0, OP_DEC1: k = K_ALU;
      OP_STOR: k = K_STOR;
      OP_PRT:  k = K_PRT;
      OP_BEEP: k = K_BEEP;
      OP_DIV:  k = K_DIV;
      OP_JEQ, OP_JNE, OP_JLT, OP_JGT, OP_JNZ, OP_JZ: k = K_JCC;
      OP_CALL: k = K_CALL;
      OP_RET:  k = K_RET;
      OP_INT, OP_CMP: k = K_NOP;
      OP_JMP:  k = K_JMP;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

endpackage

// ----- src/tac_if.sv -----
interface tac_req_if;
  import tac_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tac_res_if;
  import tac_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tac_front.sv -----
`include "toy_accumulator_cpu_execute_core_defines.svh"
module tac_front
  import tac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       q_valid,
  input  logic       q_ready,
  output dec_t       q_data
);

  // two-entry queue of decoded requests
  dec_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{kind: classify(in_data.opcode), opcode: in_data.opcode,
                       operand: in_data.operand};
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `TAC_ASSERT_IMP(a_no_overfill, cnt_r == 2'd2, !push)
  `TAC_ASSERT_NEXT(a_push_only, cnt_r == 2'd0 && !push, cnt_r == 2'd0)
  `TAC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)

endmodule

// ----- src/tac_back.sv -----
`include "toy_accumulator_cpu_execute_core_defines.svh"
module tac_back
  import tac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  dec_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [2:0]  st_r;
  logic [7:0]  pc_r, acc_r, r1_r;
  logic [LVL_W-1:0] lvl_r;
  logic        halt_r;
  dec_t        ins_r;
  res_t        res_r;
  res_t        res_nxt;
  logic [HA_W-1:0] clr_r;
  logic [7:0]  heap [HEAP_DEPTH];
  logic [7:0]  stk [STACK_DEPTH];
  logic [7:0]  rd_r;
  // divider
  logic [7:0]  quo_r, rem_r;
  logic [3:0]  dcnt_r;
  logic [8:0]  trial;
  logic [HA_W-1:0] haddr;
  logic [15:0] prod;
  logic        take;
  logic        jc;

  assign haddr    = ins_r.operand[HA_W-1:0];
  assign q_ready  = (st_r == S_IDLE);
  assign take     = q_valid && q_ready;
  assign out_valid = (st_r == S_OUT);
  assign out_data = res_r;
  assign trial    = {rem_r, quo_r[7]} - {1'b0, r1_r};
  assign prod     = acc_r * r1_r;

  always_comb begin
    unique case (ins_r.opcode)
      OP_JEQ:  jc = (acc_r == r1_r);
      OP_JNE:  jc = (acc_r != r1_r);
      OP_JLT:  jc = (acc_r < r1_r);
      OP_JGT:  jc = (acc_r > r1_r);
      OP_JNZ:  jc = (acc_r != 8'd0);
      default: jc = (acc_r == 8'd0);
    endcase
  end

  // result of the instruction held in ins_r
  always_comb begin
    res_nxt = '{next_fetch_address: pc_r, halted: halt_r, print_valid: 1'b0,
                print_address: 8'd0, print_value: 8'd0, beep: 1'b0,
                fault: FLT_NONE};
    if (!halt_r) begin
      unique case (ins_r.kind)
        K_HALT: begin
          res_nxt.halted = 1'b1;
          res_nxt.next_fetch_address = pc_r + 8'd1;
        end
        K_LDR0, K_LDR1, K_STOR: res_nxt.next_fetch_address = pc_r + 8'd2;
        K_ALU, K_NOP: res_nxt.next_fetch_address = pc_r + 8'd1;
        K_PRT: begin
          res_nxt.next_fetch_address = pc_r + 8'd2;
          res_nxt.print_valid = 1'b1;
          res_nxt.print_address = 8'(haddr);
        end
        K_BEEP: begin
          res_nxt.next_fetch_address = pc_r + 8'd1;
          res_nxt.beep = 1'b1;
        end
        K_DIV: begin
          res_nxt.next_fetch_address = pc_r + 8'd1;
          if (r1_r == 8'd0) res_nxt.fault = FLT_DIV0;
        end
        K_JCC: res_nxt.next_fetch_address = jc ? ins_r.operand : pc_r + 8'd2;
        K_CALL: begin
          if (lvl_r >= LVL_W'(STACK_DEPTH)) begin
            res_nxt.next_fetch_address = pc_r + 8'd2;
            res_nxt.fault = FLT_OVFL;
          end else begin
            res_nxt.next_fetch_address = ins_r.operand;
          end
        end
        K_RET: begin
          if (lvl_r == '0) begin
            res_nxt.next_fetch_address = pc_r + 8'd1;
            res_nxt.fault = FLT_UNFL;
          end else begin
            res_nxt.next_fetch_address = stk[SP_W'(lvl_r - 1'b1)];
          end
        end
        K_JMP: res_nxt.next_fetch_address = ins_r.operand;
        default: begin
          res_nxt.next_fetch_address = pc_r + 8'd1;
          res_nxt.fault = FLT_BADOP;
        end
      endcase
    end
  end

  // heap: cleared after reset, one entry a cycle, read registered
  always_ff @(posedge clk) begin
    if (st_r == S_CLR) heap[clr_r] <= 8'd0;
    else if (st_r == S_EXEC && !halt_r && ins_r.kind == K_STOR) heap[haddr] <= acc_r;
    rd_r <= heap[haddr];
  end

  // return stack
  always_ff @(posedge clk) begin
    if (st_r == S_EXEC && !halt_r && ins_r.kind == K_CALL && lvl_r < LVL_W'(STACK_DEPTH))
      stk[lvl_r[SP_W-1:0]] <= pc_r + 8'd2;
  end

  // sequencer and machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      clr_r  <= '0;
      pc_r   <= 8'd0;
      acc_r  <= 8'd0;
      r1_r   <= 8'd0;
      lvl_r  <= '0;
      halt_r <= 1'b0;
      dcnt_r <= 4'd0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == HA_W'(HEAP_DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (take) begin
            ins_r <= q_data;
            st_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_r <= res_nxt;
          pc_r  <= res_nxt.next_fetch_address;
          st_r  <= (!halt_r && ins_r.kind == K_PRT) ? S_RD :
                   (!halt_r && ins_r.kind == K_DIV && r1_r != 8'd0) ? S_DIV : S_OUT;
          if (!halt_r) begin
            unique case (ins_r.kind)
              K_HALT: halt_r <= 1'b1;
              K_LDR0: acc_r <= ins_r.operand;
              K_LDR1: r1_r <= ins_r.operand;
              K_ALU: begin
                case (ins_r.opcode)
                  OP_ADD:  acc_r <= acc_r + r1_r;
                  OP_MULT: acc_r <= prod[7:0];
                  OP_SUB:  acc_r <= acc_r - r1_r;
                  OP_INC0: acc_r <= acc_r + 8'd1;
                  OP_INC1: r1_r <= r1_r + 8'd1;
                  OP_DEC0: acc_r <= acc_r - 8'd1;
                  default: r1_r <= r1_r - 8'd1;
                endcase
              end
              K_DIV: begin
                if (r1_r == 8'd0) begin
                  acc_r <= 8'hFF;
                end else begin
                  quo_r  <= acc_r;
                  rem_r  <= 8'd0;
                  dcnt_r <= 4'd8;
                end
              end
              K_CALL: begin
                if (lvl_r < LVL_W'(STACK_DEPTH)) lvl_r <= lvl_r + 1'b1;
              end
              K_RET: begin
                if (lvl_r != '0) lvl_r <= lvl_r - 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          res_r.print_value <= rd_r;
          st_r <= S_OUT;
        end
        S_DIV: begin
          // one restoring step per cycle
          if (!trial[8]) begin
            rem_r <= trial[7:0];
            quo_r <= {quo_r[6:0], 1'b1};
          end else begin
            rem_r <= {rem_r[6:0], quo_r[7]};
            quo_r <= {quo_r[6:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 4'd1;
          // last step: quotient straight into the accumulator
          if (dcnt_r == 4'd1) begin
            acc_r <= {quo_r[6:0], ~trial[8]};
            st_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `TAC_ASSERT_IMP(a_lvl_range, 1'b1, lvl_r <= LVL_W'(STACK_DEPTH))
  `TAC_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r)
  `TAC_ASSERT_IMP(a_out_halt, out_valid, res_r.halted == halt_r)

endmodule

// ----- src/toy_accumulator_cpu_execute_core.sv -----
// channel | dir | payload
// in_     | in  | opcode, operand
// out_    | out | next_fetch_address, halted, print, beep, fault
// an instruction passes S_EXEC then S_OUT; print adds S_RD (heap read)
// and nonzero divide adds S_DIV (one quotient bit a cycle, restoring divider)
// after reset all 256 heap entries are cleared before any request is executed
// the front queue holds two requests, so input takes requests while a result stalls
module toy_accumulator_cpu_execute_core
  import tac_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  tac_req_if.sink   in_ch,
  tac_res_if.source out_ch
);

  logic q_valid, q_ready;
  dec_t q_data;

  // decode and queue
  tac_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_ready, .q_data
  );

  // execute
  tac_back u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

endmodule
